>>> hdl/pmec_pkg.sv
// Package for the prime-modulus exponentiation cipher core.
// Holds register indexes, opcodes and reset values; used by the top level.
`default_nettype none
package pmec_pkg;
   localparam logic [0:0] REG_MODULUS  = 1'b0;
   localparam logic [0:0] REG_EXPONENT = 1'b1;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam logic [31:0] MODULUS_RESET  = 32'd1000000787;
   localparam logic [31:0] EXPONENT_RESET = 32'd65537;
endpackage
`default_nettype wire

>>> hdl/pmec_divider.sv
// Restoring radix-2 divider shared by all modular reductions of the core.
// One quotient bit per cycle; no dependencies besides its own parameter.
`default_nettype none
module pmec_divider #(
   parameter int VALUE_BITS = 31
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [2*VALUE_BITS-1:0]   dividend,
   input  wire logic [VALUE_BITS-1:0]     divisor,
   output logic                           done,
   output logic [2*VALUE_BITS-1:0]        quotient,
   output logic [VALUE_BITS-1:0]          remainder
);
   localparam int DW = 2 * VALUE_BITS;
   localparam int CW = $clog2(DW);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DW-1:0]         quo_ff, quo_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] dvs_ff, dvs_in;
   logic [VALUE_BITS:0]   trial;
   logic                  fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DW-1]};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? VALUE_BITS'(trial - {1'b0, dvs_ff}) : trial[VALUE_BITS-1:0];
         quo_in = {quo_ff[DW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

>>> hdl/prime_modulus_exponent_cipher_core.sv
// Top level of the prime-modulus exponentiation cipher core.
// Depends on pmec_pkg and pmec_divider.
`default_nettype none
//
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tuser: opcode; tdata: value
// rsp       out        rsp_tvalid/rsp_tready  tdata: result
// csr       in         csr_we (no wait)       csr_index, csr_wdata
//
// One transaction is worked on at a time; req_tready is high only while the
// sequencer is idle. Every modular reduction runs through the shared divider
// at one bit per cycle. Decrypt adds a trial-division totient of modulus-1
// (up to about 46000 candidate factors, each one divider pass) and a second
// exponentiation. Reset is synchronous; it clears the sequencer and the
// output valid and loads the modulus and exponent reset values. A result
// waiting on rsp does not stop the next request from being taken; the
// sequencer only holds its new result until the output register is free.
module prime_modulus_exponent_cipher_core #(
   parameter int VALUE_BITS = 31
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [((VALUE_BITS+7)/8)*8-1:0]     req_tdata,  // [VALUE_BITS-1:0] value
   input  wire logic                                req_tuser,  // [0] opcode
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [((VALUE_BITS+7)/8)*8-1:0]          rsp_tdata,  // [VALUE_BITS-1:0] result
   input  wire logic                                csr_we,
   input  wire logic [0:0]                          csr_index,
   input  wire logic [VALUE_BITS-1:0]               csr_wdata
);
   localparam int W   = VALUE_BITS;
   localparam int TW  = ((VALUE_BITS + 7) / 8) * 8;
   localparam int BW  = $clog2(VALUE_BITS);
   localparam int PW  = (VALUE_BITS + 1) / 2 + 2;

   // Sequencer state codes.
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_WAIT  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_MODL  = 4'd3;
   localparam logic [3:0] S_PBASE = 4'd4;
   localparam logic [3:0] S_PSQ   = 4'd5;
   localparam logic [3:0] S_PML   = 4'd6;
   localparam logic [3:0] S_TSQ   = 4'd7;
   localparam logic [3:0] S_TCMP  = 4'd8;
   localparam logic [3:0] S_TDX   = 4'd9;
   localparam logic [3:0] S_TDT   = 4'd10;
   localparam logic [3:0] S_TUPD  = 4'd11;
   localparam logic [3:0] S_TFIN  = 4'd12;
   localparam logic [3:0] S_TEND  = 4'd13;
   localparam logic [3:0] S_DONE  = 4'd14;

   // Configuration registers.
   logic [W-1:0] modulus_ff, modulus_in;
   logic [W-1:0] exponent_ff, exponent_in;

   // Sequencer registers.
   logic [3:0]    state_ff, state_in;
   logic [3:0]    ret_ff, ret_in;
   logic          modafter_ff, modafter_in;
   logic          phase_d_ff, phase_d_in;   // high while computing the private exponent
   logic          found_ff, found_in;
   logic [W-1:0]  n_ff, n_in;
   logic [W-1:0]  v_ff, v_in;
   logic [W-1:0]  m_ff, m_in;
   logic [W-1:0]  ex_ff, ex_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  t_ff, t_in;
   logic [PW-1:0] p_ff, p_in;
   logic [W-1:0]  mula_ff, mula_in;
   logic [W-1:0]  mulb_ff, mulb_in;
   logic [2*W-1:0] prod_ff, prod_in;
   logic [W-1:0]  res_ff, res_in;
   logic          rspv_ff, rspv_in;
   logic [W-1:0]  rspd_ff, rspd_in;

   // Divider interface.
   logic           div_start;
   logic [2*W-1:0] div_a;
   logic [W-1:0]   div_b;
   logic           div_done;
   logic [2*W-1:0] div_q;
   logic [W-1:0]   div_r;

   // Shared launch requests, resolved after the state case.
   logic          pm_go;
   logic [W-1:0]  pm_base, pm_ex, pm_m;
   logic          pm_d;
   logic          sq_go;
   logic [W-1:0]  sq_val;
   logic          next_go;
   logic [W-1:0]  next_acc;
   logic          req_acc;

   pmec_divider #(.VALUE_BITS(VALUE_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      modulus_in  = modulus_ff;
      exponent_in = exponent_ff;
      if (csr_we) begin
         if (csr_index == pmec_pkg::REG_MODULUS) begin
            modulus_in = csr_wdata;
         end else begin
            exponent_in = csr_wdata;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      modafter_in = modafter_ff;
      phase_d_in  = phase_d_ff;
      found_in    = found_ff;
      n_in        = n_ff;
      v_in        = v_ff;
      m_in        = m_ff;
      ex_in       = ex_ff;
      b_in        = b_ff;
      acc_in      = acc_ff;
      bit_in      = bit_ff;
      x_in        = x_ff;
      t_in        = t_ff;
      p_in        = p_ff;
      mula_in     = mula_ff;
      mulb_in     = mulb_ff;
      prod_in     = prod_ff;
      res_in      = res_ff;
      div_start   = 1'b0;
      div_a       = prod_ff;
      div_b       = m_ff;
      pm_go       = 1'b0;
      pm_base     = v_ff;
      pm_ex       = exponent_ff;
      pm_m        = n_ff;
      pm_d        = 1'b0;
      sq_go       = 1'b0;
      sq_val      = acc_ff;
      next_go     = 1'b0;
      next_acc    = div_r;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               n_in = modulus_ff;
               v_in = req_tdata[W-1:0];
               if (modulus_ff < W'(2)) begin
                  res_in   = '0;
                  state_in = S_DONE;
               end else if (req_tuser == pmec_pkg::OP_ENCRYPT) begin
                  pm_go   = 1'b1;
                  pm_base = req_tdata[W-1:0];
                  pm_m    = modulus_ff;
               end else begin
                  // Totient of modulus-1 by trial division.
                  x_in     = modulus_ff - 1'b1;
                  t_in     = modulus_ff - 1'b1;
                  p_in     = PW'(2);
                  found_in = 1'b0;
                  state_in = S_TSQ;
               end
            end
         end
         S_WAIT: begin
            if (div_done) begin
               state_in = ret_ff;
            end
         end
         S_MUL: begin
            prod_in  = mula_ff * mulb_ff;
            state_in = modafter_ff ? S_MODL : ret_ff;
         end
         S_MODL: begin
            div_start = 1'b1;
            div_a     = prod_ff;
            div_b     = m_ff;
            state_in  = S_WAIT;
         end
         S_PBASE: begin
            b_in   = div_r;
            bit_in = BW'(W - 1);
            sq_go  = 1'b1;
            sq_val = (m_ff == W'(1)) ? '0 : W'(1);
         end
         S_PSQ: begin
            acc_in = div_r;
            if (ex_ff[bit_ff]) begin
               mula_in     = div_r;
               mulb_in     = b_ff;
               modafter_in = 1'b1;
               ret_in      = S_PML;
               state_in    = S_MUL;
            end else begin
               next_go = 1'b1;
            end
         end
         S_PML: begin
            acc_in  = div_r;
            next_go = 1'b1;
         end
         S_TSQ: begin
            mula_in     = W'(p_ff);
            mulb_in     = W'(p_ff);
            modafter_in = 1'b0;
            ret_in      = S_TCMP;
            state_in    = S_MUL;
         end
         S_TCMP: begin
            if (prod_ff > {{W{1'b0}}, x_ff}) begin
               if (x_ff > W'(1)) begin
                  div_start = 1'b1;
                  div_a     = {{W{1'b0}}, t_ff};
                  div_b     = x_ff;
                  ret_in    = S_TFIN;
                  state_in  = S_WAIT;
               end else begin
                  pm_go   = 1'b1;
                  pm_d    = 1'b1;
                  pm_base = exponent_ff;
                  pm_ex   = t_ff - 1'b1;
                  pm_m    = n_ff - 1'b1;
               end
            end else begin
               div_start = 1'b1;
               div_a     = {{W{1'b0}}, x_ff};
               div_b     = W'(p_ff);
               ret_in    = S_TDX;
               state_in  = S_WAIT;
            end
         end
         S_TDX: begin
            if (div_r == '0) begin
               // Strip every power of this factor from x.
               x_in      = div_q[W-1:0];
               found_in  = 1'b1;
               div_start = 1'b1;
               div_a     = div_q;
               div_b     = W'(p_ff);
               ret_in    = S_TDX;
               state_in  = S_WAIT;
            end else if (found_ff) begin
               div_start = 1'b1;
               div_a     = {{W{1'b0}}, t_ff};
               div_b     = W'(p_ff);
               ret_in    = S_TDT;
               state_in  = S_WAIT;
            end else begin
               p_in     = p_ff + 1'b1;
               state_in = S_TSQ;
            end
         end
         S_TDT: begin
            mula_in     = div_q[W-1:0];
            mulb_in     = W'(p_ff - 1'b1);
            modafter_in = 1'b0;
            ret_in      = S_TUPD;
            state_in    = S_MUL;
         end
         S_TUPD: begin
            t_in     = prod_ff[W-1:0];
            found_in = 1'b0;
            p_in     = p_ff + 1'b1;
            state_in = S_TSQ;
         end
         S_TFIN: begin
            mula_in     = div_q[W-1:0];
            mulb_in     = x_ff - 1'b1;
            modafter_in = 1'b0;
            ret_in      = S_TEND;
            state_in    = S_MUL;
         end
         S_TEND: begin
            pm_go   = 1'b1;
            pm_d    = 1'b1;
            pm_base = exponent_ff;
            pm_ex   = prod_ff[W-1:0] - 1'b1;
            pm_m    = n_ff - 1'b1;
         end
         S_DONE: begin
            if (!rspv_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // End of one square-and-multiply step.
      if (next_go) begin
         if (bit_ff == '0) begin
            if (phase_d_ff) begin
               pm_go   = 1'b1;
               pm_base = v_ff;
               pm_ex   = next_acc;
               pm_m    = n_ff;
            end else begin
               res_in   = next_acc;
               state_in = S_DONE;
            end
         end else begin
            bit_in = bit_ff - 1'b1;
            sq_go  = 1'b1;
            sq_val = next_acc;
         end
      end

      if (sq_go) begin
         acc_in      = sq_val;
         mula_in     = sq_val;
         mulb_in     = sq_val;
         modafter_in = 1'b1;
         ret_in      = S_PSQ;
         state_in    = S_MUL;
      end

      // Start an exponentiation: reduce the base first.
      if (pm_go) begin
         m_in       = pm_m;
         ex_in      = pm_ex;
         phase_d_in = pm_d;
         div_start  = 1'b1;
         div_a      = {{W{1'b0}}, pm_base};
         div_b      = pm_m;
         ret_in     = S_PBASE;
         state_in   = S_WAIT;
      end
   end

   always_comb begin
      rspv_in = rspv_ff;
      rspd_in = rspd_ff;
      if (rspv_ff && rsp_tready) begin
         rspv_in = 1'b0;
      end
      if (state_ff == S_DONE && (!rspv_ff || rsp_tready)) begin
         rspv_in = 1'b1;
         rspd_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= W'(pmec_pkg::MODULUS_RESET);
         exponent_ff <= W'(pmec_pkg::EXPONENT_RESET);
         state_ff    <= S_IDLE;
         rspv_ff     <= 1'b0;
      end else begin
         modulus_ff  <= modulus_in;
         exponent_ff <= exponent_in;
         state_ff    <= state_in;
         rspv_ff     <= rspv_in;
      end
      ret_ff      <= ret_in;
      modafter_ff <= modafter_in;
      phase_d_ff  <= phase_d_in;
      found_ff    <= found_in;
      n_ff        <= n_in;
      v_ff        <= v_in;
      m_ff        <= m_in;
      ex_ff       <= ex_in;
      b_ff        <= b_in;
      acc_ff      <= acc_in;
      bit_ff      <= bit_in;
      x_ff        <= x_in;
      t_ff        <= t_in;
      p_ff        <= p_in;
      mula_ff     <= mula_in;
      mulb_ff     <= mulb_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      rspd_ff     <= rspd_in;
   end

   assign rsp_tvalid = rspv_ff;
   assign rsp_tdata  = TW'(rspd_ff);
endmodule
`default_nettype wire

>>> hdl/pmec_checker.sv
// Port-level checker for the cipher core, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module pmec_checker #(
   parameter int VALUE_BITS = 31
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [((VALUE_BITS+7)/8)*8-1:0] rsp_tdata
);
   localparam int TW = ((VALUE_BITS + 7) / 8) * 8;

   // A stalled result holds its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp payload changed while stalled");

   // The core works on one transaction at a time.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // No result can appear the cycle after an accepted request.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared without work");

   // Reset leaves the result channel empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Results stay below 2^VALUE_BITS.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >> VALUE_BITS) == TW'(0))
      else $error("padding bits set on result");
endmodule

bind prime_modulus_exponent_cipher_core pmec_checker #(.VALUE_BITS(VALUE_BITS)) u_pmec_checker (.*);
`default_nettype wire
